// ===== design/backslash_unescape_utf8_assert.svh =====
// Assertion macros for the backslash unescape block.
// Taken in by the modules that check their own logic; expects clk and rst_n in scope.
`ifndef BACKSLASH_UNESCAPE_UTF8_ASSERT_SVH
`define BACKSLASH_UNESCAPE_UTF8_ASSERT_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is held
`define BSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds in and out of reset
`define BSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSU_ASSERT(lbl, prop, msg)
`define BSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/bsu_pkg.sv =====
// Types, character codes and helper functions of the backslash unescape block.
// No dependencies; used by the decoder, the result buffer and the top level of the block.
package bsu_pkg;

  localparam int MAX_RES = 5;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // control byte values of the short escapes
  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0C;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;
  localparam logic [7:0] HT_CODE = 8'h09;
  localparam logic [7:0] VT_CODE = 8'h0B;

  // escape decoder modes
  typedef enum logic [7:0] {
    M_IDLE     = 8'b0000_0001,
    M_BSLASH   = 8'b0000_0010,
    M_HEXX     = 8'b0000_0100,
    M_HEXU     = 8'b0000_1000,
    M_OCTAL    = 8'b0001_0000,
    M_SURR_BS  = 8'b0010_0000,
    M_SURR_U   = 8'b0100_0000,
    M_SURR_HEX = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [2:0]   cnt;      // digits collected
    logic [15:0]  val;      // their value
    logic [15:0]  first;    // first unit of a surrogate pair
    logic         discard;  // string already invalid
    logic [23:0]  pend;     // raw digit bytes, oldest in the low byte
  } state_t;

  localparam state_t ST_RESET = '{mode: M_IDLE, cnt: 3'd0, val: 16'd0, first: 16'd0,
                                  discard: 1'b0, pend: 24'd0};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       bad_surrogate;
  } res_word_t;

  // results of one input word, slot 0 goes out first
  typedef struct packed {
    res_word_t [MAX_RES-1:0] w;
    logic [2:0]              n;
  } res_list_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= CH_0 && c <= CH_9) h = {1'b1, 4'(c - CH_0)};
    else if (c >= CH_LA && c <= CH_LF) h = {1'b1, 4'(c - CH_LA + 8'd10)};
    else if (c >= CH_UA && c <= CH_UF) h = {1'b1, 4'(c - CH_UA + 8'd10)};
    return h;
  endfunction

  // append one plain byte, dropped once the list is full
  function automatic res_list_t push_byte(input res_list_t l, input logic [7:0] b);
    res_list_t r;
    r = l;
    if (l.n < 3'(MAX_RES)) begin
      r.w[l.n] = '{out_byte: b, end_of_string: 1'b0, bad_surrogate: 1'b0};
      r.n = l.n + 3'd1;
    end
    return r;
  endfunction

  // letter of a failed hex escape and the digits seen so far
  function automatic res_list_t push_flush(input res_list_t l, input logic [7:0] letter,
                                           input logic [2:0] cnt, input logic [23:0] pend);
    res_list_t r;
    r = push_byte(l, letter);
    if (cnt > 3'd0) r = push_byte(r, pend[7:0]);
    if (cnt > 3'd1) r = push_byte(r, pend[15:8]);
    if (cnt > 3'd2) r = push_byte(r, pend[23:16]);
    return r;
  endfunction

  // UTF-8 encoding of a code point below 0x110000
  function automatic res_list_t push_utf8(input res_list_t l, input logic [20:0] cp);
    res_list_t r;
    r = l;
    if (cp < 21'h80) begin
      r = push_byte(r, cp[7:0]);
    end else if (cp < 21'h800) begin
      r = push_byte(r, {3'b110, cp[10:6]});
      r = push_byte(r, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      r = push_byte(r, {4'b1110, cp[15:12]});
      r = push_byte(r, {2'b10, cp[11:6]});
      r = push_byte(r, {2'b10, cp[5:0]});
    end else begin
      r = push_byte(r, {5'b11110, cp[20:18]});
      r = push_byte(r, {2'b10, cp[17:12]});
      r = push_byte(r, {2'b10, cp[11:6]});
      r = push_byte(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

endpackage

// ===== design/bsu_if.sv =====
// Valid/ready channel interfaces of the backslash unescape block.
// Depends on nothing; the input carries raw bytes, the output decoded words.
interface bsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface bsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       bad_surrogate;

  modport source (output valid, output out_byte, output end_of_string,
                  output bad_surrogate, input ready);
  modport sink   (input valid, input out_byte, input end_of_string,
                  input bad_surrogate, output ready);
endinterface

// ===== design/bsu_decode.sv =====
// Combinational escape decoder: one raw byte and the decoder state in,
// next state and up to five result words out. Uses bsu_pkg.
module bsu_decode
  import bsu_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output state_t     nst,
  output res_list_t  res
);

  logic [4:0]  hx;
  logic        is_oct;
  logic [2:0]  cnt1;
  logic [15:0] val1;
  logic [15:0] oct_nv;
  logic [10:0] pair_hi;
  logic [20:0] cp_pair;
  logic        redo;

  // digit helpers, from the input byte and the current state
  assign hx      = hex_digit(in_byte);
  assign is_oct  = (in_byte >= CH_0) && (in_byte <= CH_7);
  assign cnt1    = st.cnt + 3'd1;
  assign val1    = {st.val[11:0], hx[3:0]};
  assign oct_nv  = {st.val[12:0], in_byte[2:0]};
  // supplementary code point: low ten bits never carry into the high part
  assign pair_hi = {1'b0, st.first[9:0]} + 11'h040;
  assign cp_pair = {pair_hi, val1[9:0]};

  always_comb begin
    nst  = st;
    res  = '0;
    redo = 1'b0;

    if (!st.discard) begin
      unique case (st.mode)
        M_IDLE: begin
          if (in_byte == CH_BSLASH) nst.mode = M_BSLASH;
          else res = push_byte(res, in_byte);
        end
        M_BSLASH: begin
          nst.mode = M_IDLE;
          nst.cnt  = '0;
          nst.val  = '0;
          nst.pend = '0;
          case (in_byte)
            CH_B:    res = push_byte(res, BS_CODE);
            CH_F:    res = push_byte(res, FF_CODE);
            CH_N:    res = push_byte(res, LF_CODE);
            CH_R:    res = push_byte(res, CR_CODE);
            CH_T:    res = push_byte(res, HT_CODE);
            CH_V:    res = push_byte(res, VT_CODE);
            CH_X:    nst.mode = M_HEXX;
            CH_U:    nst.mode = M_HEXU;
            default: begin
              if (is_oct) begin
                nst.mode = M_OCTAL;
                nst.cnt  = 3'd1;
                nst.val  = {13'd0, in_byte[2:0]};
              end else begin
                res = push_byte(res, in_byte);
              end
            end
          endcase
        end
        M_HEXX, M_HEXU: begin
          if (!hx[4]) begin
            // not a digit: letter and digits go out literally, byte is decoded again
            res = push_flush(res, (st.mode == M_HEXX) ? CH_X : CH_U, st.cnt, st.pend);
            nst.mode = M_IDLE;
            nst.cnt  = '0;
            nst.val  = '0;
            nst.pend = '0;
            redo     = 1'b1;
          end else if ((st.mode == M_HEXX && cnt1 >= 3'd2) || cnt1 >= 3'd4) begin
            nst.mode = M_IDLE;
            nst.cnt  = '0;
            nst.val  = '0;
            nst.pend = '0;
            if (st.mode == M_HEXX) begin
              res = push_byte(res, val1[7:0]);
            end else if (val1[15:11] == 5'b11011) begin
              // high or low surrogate: wait for the second unit
              nst.first = val1;
              nst.mode  = M_SURR_BS;
            end else begin
              res = push_utf8(res, {5'd0, val1});
            end
          end else begin
            nst.cnt = cnt1;
            nst.val = val1;
            case (st.cnt[1:0])
              2'd0:    nst.pend[7:0]   = in_byte;
              2'd1:    nst.pend[15:8]  = in_byte;
              2'd2:    nst.pend[23:16] = in_byte;
              default: nst.pend        = st.pend;
            endcase
          end
        end
        M_OCTAL: begin
          if (is_oct && st.cnt < 3'd2) begin
            nst.val = oct_nv;
            nst.cnt = 3'd2;
          end else begin
            nst.mode = M_IDLE;
            nst.cnt  = '0;
            nst.val  = '0;
            nst.pend = '0;
            if (is_oct && oct_nv[15:8] == 8'd0) begin
              res = push_byte(res, oct_nv[7:0]);
            end else begin
              // third digit would overflow, or no digit at all
              res  = push_byte(res, st.val[7:0]);
              redo = 1'b1;
            end
          end
        end
        M_SURR_BS: begin
          if (in_byte == CH_BSLASH) begin
            nst.mode = M_SURR_U;
          end else begin
            nst.discard = 1'b1;
            nst.mode    = M_IDLE;
            nst.cnt     = '0;
            nst.val     = '0;
            nst.pend    = '0;
          end
        end
        M_SURR_U: begin
          nst.cnt  = '0;
          nst.val  = '0;
          nst.pend = '0;
          if (in_byte == CH_U) begin
            nst.mode = M_SURR_HEX;
          end else begin
            nst.discard = 1'b1;
            nst.mode    = M_IDLE;
          end
        end
        M_SURR_HEX: begin
          if (!hx[4]) begin
            nst.discard = 1'b1;
            nst.mode    = M_IDLE;
            nst.cnt     = '0;
            nst.val     = '0;
            nst.pend    = '0;
          end else if (cnt1 >= 3'd4) begin
            res       = push_utf8(res, cp_pair);
            nst.mode  = M_IDLE;
            nst.cnt   = '0;
            nst.val   = '0;
            nst.pend  = '0;
            nst.first = '0;
          end else begin
            nst.cnt = cnt1;
            nst.val = val1;
          end
        end
        default: begin
          nst.mode = M_IDLE;
          nst.cnt  = '0;
          nst.val  = '0;
          nst.pend = '0;
          redo     = 1'b1;
        end
      endcase

      // second pass from idle for a byte that ended an escape
      if (redo) begin
        if (in_byte == CH_BSLASH) nst.mode = M_BSLASH;
        else res = push_byte(res, in_byte);
      end
    end

    // string end: close any pending escape, then return to reset
    if (string_end) begin
      if (!nst.discard) begin
        case (nst.mode)
          M_BSLASH:   res = push_byte(res, 8'h00);
          M_HEXX:     res = push_flush(res, CH_X, nst.cnt, nst.pend);
          M_HEXU:     res = push_flush(res, CH_U, nst.cnt, nst.pend);
          M_OCTAL:    res = push_byte(res, nst.val[7:0]);
          M_SURR_BS, M_SURR_U, M_SURR_HEX: nst.discard = 1'b1;
          default:    res = res;
        endcase
      end
      if (nst.discard) begin
        if (res.n >= 3'(MAX_RES)) res.n = 3'(MAX_RES - 1);
        res.w[res.n] = '{out_byte: 8'h00, end_of_string: 1'b0, bad_surrogate: 1'b1};
        res.n        = res.n + 3'd1;
      end
      if (res.n != 3'd0) res.w[res.n - 3'd1].end_of_string = 1'b1;
      nst = ST_RESET;
    end
  end

endmodule

// ===== design/bsu_outbuf.sv =====
// Result buffer: holds the words of one decoded byte and sends them one per cycle while the output is ready.
// Uses bsu_pkg, bsu_out_if and the assertion macro header.
`include "backslash_unescape_utf8_assert.svh"
module bsu_outbuf
  import bsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  res_list_t        res,
  output logic             can_load,
  bsu_out_if.source        out_if
);

  res_list_t  list_r;
  logic [2:0] rem_r, rem_nxt;
  logic [2:0] ptr_r, ptr_nxt;
  logic       take;
  res_word_t  word;

  assign take     = out_if.valid && out_if.ready;
  // free now, or its last word leaves this cycle
  assign can_load = (rem_r == 3'd0) || (rem_r == 3'd1 && out_if.ready);

  always_comb begin
    rem_nxt = rem_r;
    ptr_nxt = ptr_r;
    if (load) begin
      rem_nxt = res.n;
      ptr_nxt = 3'd0;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      ptr_nxt = ptr_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      ptr_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // word payload, no reset
  always_ff @(posedge clk) begin
    if (load) list_r <= res;
  end

  assign word                 = list_r.w[ptr_r];
  assign out_if.valid         = (rem_r != 3'd0);
  assign out_if.out_byte      = word.out_byte;
  assign out_if.end_of_string = word.end_of_string;
  assign out_if.bad_surrogate = word.bad_surrogate;

  `BSU_ASSERT(a_buf_in_range, ({1'b0, ptr_r} + {1'b0, rem_r}) <= 4'd5, "buffer pointer past the last slot")
  `BSU_ASSERT(a_eos_is_last, (out_if.valid && word.end_of_string) |-> (rem_r == 3'd1), "end of string before the last word")
  `BSU_ASSERT(a_err_closes, (out_if.valid && word.bad_surrogate) |-> (word.end_of_string && word.out_byte == 8'h00), "error word does not close the string")
  `BSU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (rem_r == 3'd0), "buffer not empty after reset")

endmodule

// ===== design/backslash_unescape_utf8.sv =====
// Top level of the backslash unescape block: input register, decoder state, result buffer.
// Uses bsu_pkg, bsu_if, bsu_decode, bsu_outbuf and the assertion macro header.
//
// Decodes an escaped string fed one byte per word (string_end on its last byte) into raw
// bytes and UTF-8: the quote/slash/backslash and b f n r t v escapes, \x with two hex
// digits, octal with up to three digits (value at most 255), \u with four hex digits and
// surrogate pairs written as two \u units. Each byte gives zero to five result words; the
// last word of every string has end_of_string set, and a broken surrogate pair closes its
// string with a single word of 0 with bad_surrogate set, the bytes after its first unit
// giving nothing. A byte waits in the input register, then is decoded straight into the
// result buffer. The input takes one byte per cycle while the output is ready and each
// byte yields at most one word; a byte yielding more holds the next byte until its last
// word leaves, as the result buffer sends one word per ready cycle and takes new words
// only then. No stall on one side blocks the other beyond that buffer.
`include "backslash_unescape_utf8_assert.svh"
module backslash_unescape_utf8
  import bsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bsu_in_if.sink     in_if,
  bsu_out_if.source  out_if
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  state_t     st_r, st_nxt;
  state_t     dec_st;
  res_list_t  dec_res;
  logic       can_load;
  logic       fire;

  // decode the held byte whenever the result buffer can take its words
  assign fire        = in_vld_r && can_load;
  assign in_if.ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_if.valid && in_if.ready) in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.in_byte;
      in_end_r  <= in_if.string_end;
    end
  end

  bsu_decode u_decode (
    .st         (st_r),
    .in_byte    (in_byte_r),
    .string_end (in_end_r),
    .nst        (dec_st),
    .res        (dec_res)
  );

  // decoder state advances once per decoded byte
  assign st_nxt = fire ? dec_st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_RESET;
    else st_r <= st_nxt;
  end

  bsu_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (dec_res),
    .can_load (can_load),
    .out_if   (out_if)
  );

  `BSU_ASSERT(a_discard_idle, st_r.discard |-> (st_r.mode == M_IDLE && st_r.cnt == 3'd0), "invalid string left an escape pending")
  `BSU_ASSERT(a_end_resets, (fire && in_end_r) |=> (st_r == ST_RESET), "state not cleared after string end")
  `BSU_ASSERT(a_no_loss, (in_vld_r && !fire) |=> (in_vld_r && $stable(in_byte_r)), "held byte lost before decode")

endmodule
